@@ rtl/rsba_pkg.sv @@
// Package for the ring segment buffer allocator.
// Holds the ring geometry, the header and result types, and the control and status
// structs shared by the controller, the datapath and the top level.
package rsba_pkg;

  // Ring geometry
  localparam int MEM_BYTES  = 65536;
  localparam int MAX_BLOCK  = 2048;
  localparam int HDR_BYTES  = 32;
  localparam int ROUND_ADD  = 7;
  localparam int SLOTS      = MEM_BYTES / 8;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int WRAP_LIMIT = MEM_BYTES - HDR_BYTES - MAX_BLOCK;
  // Positions can run past the ring end by one header plus one block
  localparam int POS_W      = $clog2(MEM_BYTES + HDR_BYTES + MAX_BLOCK + 8);
  // Segment size is held in units of 8 bytes, so the low three bits are implied zero
  localparam int SIZE_W     = $clog2((MAX_BLOCK + ROUND_ADD) / 8 + 1);
  localparam int HDR_W      = SIZE_W + 1;
  // Upper bound on head-walk steps before the walk is abandoned
  localparam int WALK_CAP   = 2 * SLOTS + 4;
  localparam int STEP_W     = $clog2(WALK_CAP + 1);

  // Field widths
  localparam int LEN_W   = 12;
  localparam int OFF_W   = 16;
  localparam int GRANT_W = 16;
  localparam int STAT_W  = 2;

  // Result codes
  typedef enum logic [STAT_W-1:0] {
    RS_OK      = 2'd0,
    RS_NOSPACE = 2'd1,
    RS_GUARD   = 2'd2
  } rsba_res_t;

  // One header slot: size in 8-byte units and the in-use mark
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              used;
  } rsba_hdr_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      capture;    // latch the accepted request
    logic      rd_pos;     // read the header at the request position
    logic      clr_wr;     // clearing pass write
    logic      alloc_wr;   // commit an allocation
    logic      free_wr;    // clear the in-use mark of the freed header
    logic      walk_init;  // start a head walk
    logic      step;       // advance the head by one segment
    logic      hrd_load;   // take the size of the header at the new head
    logic      set_res;    // overwrite the result code
    rsba_res_t res_code;
    logic      out_load;   // move the result into the output register
  } rsba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;   // last slot of the clearing pass
    logic is_free;    // latched request is a free
    logic bad_off;    // latched free offset is not a header in the ring
    logic used;       // header read last cycle is in use
    logic at_head;    // request position equals the head
    logic cap_hit;    // walk step budget exhausted
    logic sum_eq;     // advanced head lands on the tail
    logic guard;      // advanced head passed the tail after a wrap
    logic wrap_eq;    // head after wrapping lands on the tail
    logic out_free;   // output register can take a result
  } rsba_sts_t;

endpackage

@@ rtl/rsba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rsba_ctrl.sv @@
// Controller state machine of the ring segment buffer allocator.
// Sequences the clearing pass, allocate, free and the head walk; uses rsba_pkg.
module rsba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rsba_pkg::rsba_sts_t sts,
  output rsba_pkg::rsba_cmd_t cmd
);
  import rsba_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_ALLOC = 8'b0000_1000,
    ST_FREE  = 8'b0001_0000,
    ST_STEP  = 8'b0010_0000,
    ST_HRD   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = RS_OK;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_pos = 1'b1;
        if (sts.is_free && sts.bad_off) begin
          state_nxt = ST_DONE;
        end else if (sts.is_free) begin
          state_nxt = ST_FREE;
        end else begin
          state_nxt = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (sts.used) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RS_NOSPACE;
        end else begin
          cmd.alloc_wr = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_FREE: begin
        cmd.free_wr = 1'b1;
        if (sts.at_head) begin
          cmd.walk_init = 1'b1;
          state_nxt     = ST_STEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_STEP: begin
        if (sts.cap_hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RS_GUARD;
          state_nxt    = ST_DONE;
        end else begin
          cmd.step = 1'b1;
          if (sts.sum_eq) begin
            state_nxt = ST_DONE;
          end else if (sts.guard) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = RS_GUARD;
            state_nxt    = ST_DONE;
          end else if (sts.wrap_eq) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_HRD;
          end
        end
      end
      ST_HRD: begin
        if (sts.used) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.hrd_load = 1'b1;
          state_nxt    = ST_STEP;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/rsba_dp.sv @@
// Datapath of the ring segment buffer allocator.
// Holds head, tail, walk registers, the header store and the output register;
// uses rsba_pkg and rsba_ram.
module rsba_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [31:0]                  in_tdata,   // [11:0] length, [27:12] offset
  input  logic                         in_tuser,   // [0] cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [15:0] granted_offset
  output logic [1:0]                   out_tuser,  // [1:0] status
  input  rsba_pkg::rsba_cmd_t          cmd,
  output rsba_pkg::rsba_sts_t          sts
);
  import rsba_pkg::*;

  logic [POS_W-1:0]   head_r, head_nxt;
  logic [POS_W-1:0]   tail_r;
  logic [POS_W-1:0]   pos_r;
  logic [SIZE_W-1:0]  size_r;
  logic [STEP_W-1:0]  steps_r;
  logic               wrapped_r;
  logic               is_free_r;
  logic               bad_r;
  logic [SLOT_W-1:0]  clr_idx_r;
  rsba_res_t          res_code_r;
  logic [GRANT_W-1:0] res_grant_r;
  logic               out_valid_r;
  rsba_res_t          out_code_r;
  logic [GRANT_W-1:0] out_grant_r;

  // Request fields
  logic [LEN_W-1:0]   in_len;
  logic [OFF_W-1:0]   in_off;
  logic [LEN_W-1:0]   len_clip;
  logic [SIZE_W-1:0]  size_in;
  logic [OFF_W-1:0]   off_sub;
  logic               off_bad;
  logic [POS_W-1:0]   alloc_pos;

  // Walk arithmetic
  logic [POS_W-1:0]   sum;
  logic               wrap_take;
  logic [POS_W-1:0]   hw;
  logic               sum_eq;
  logic               guard;

  // Header store ports
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  rsba_hdr_t          ram_wdata;
  logic [SLOT_W-1:0]  ram_raddr;
  rsba_hdr_t          ram_rdata;

  assign in_len = in_tdata[LEN_W-1:0];
  assign in_off = in_tdata[LEN_W+OFF_W-1:LEN_W];

  // Clip the length to one block and round up to 8 bytes
  assign len_clip = (32'(in_len) > MAX_BLOCK) ? LEN_W'(MAX_BLOCK) : in_len;
  assign size_in  = SIZE_W'(({1'b0, len_clip} + (LEN_W+1)'(ROUND_ADD)) >> 3);

  // Free offset checks: header below zero, misaligned, or outside the ring
  assign off_sub = in_off - OFF_W'(HDR_BYTES);
  assign off_bad = (in_off < OFF_W'(HDR_BYTES)) || (in_off[2:0] != 3'd0) ||
                   (32'(off_sub) >= MEM_BYTES);

  // Wrap the tail when a header plus a block no longer fits
  assign alloc_pos = (tail_r > POS_W'(WRAP_LIMIT)) ? '0 : tail_r;

  // Next head candidate and its checks against the tail
  assign sum       = head_r + POS_W'(HDR_BYTES) + (POS_W'(size_r) << 3);
  assign wrap_take = (sum > POS_W'(WRAP_LIMIT));
  assign hw        = wrap_take ? '0 : sum;
  assign sum_eq    = (sum == tail_r);
  assign guard     = wrapped_r && (sum > tail_r);
  assign head_nxt  = (sum_eq || guard) ? sum : hw;

  // Header store address and data
  always_comb begin
    ram_we    = cmd.clr_wr || cmd.alloc_wr || cmd.free_wr;
    ram_waddr = cmd.clr_wr ? clr_idx_r : SLOT_W'(pos_r >> 3);
    ram_wdata = '0;
    if (cmd.alloc_wr) begin
      ram_wdata.size = size_r;
      ram_wdata.used = 1'b1;
    end else if (cmd.free_wr) begin
      ram_wdata.size = ram_rdata.size;
      ram_wdata.used = 1'b0;
    end
    ram_raddr = cmd.rd_pos ? SLOT_W'(pos_r >> 3) : SLOT_W'(hw >> 3);
  end

  rsba_ram #(
    .WIDTH (HDR_W),
    .DEPTH (SLOTS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Head, tail and clearing pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx_r <= clr_idx_r + SLOT_W'(1);
      end
      if (cmd.alloc_wr) begin
        tail_r <= pos_r + POS_W'(HDR_BYTES) + (POS_W'(size_r) << 3);
      end
      if (cmd.step) begin
        head_r <= head_nxt;
      end
    end
  end

  // Request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_free_r <= in_tuser;
      bad_r     <= off_bad;
      pos_r     <= in_tuser ? POS_W'(off_sub) : alloc_pos;
      size_r    <= size_in;
    end else if (cmd.walk_init || cmd.hrd_load) begin
      size_r <= ram_rdata.size;
    end
    if (cmd.walk_init) begin
      steps_r   <= '0;
      wrapped_r <= 1'b0;
    end else if (cmd.step) begin
      steps_r   <= steps_r + STEP_W'(1);
      wrapped_r <= wrapped_r || wrap_take;
    end
  end

  // Result being built
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_code_r  <= RS_OK;
      res_grant_r <= '0;
    end else begin
      if (cmd.set_res) begin
        res_code_r <= cmd.res_code;
      end
      if (cmd.alloc_wr) begin
        res_grant_r <= GRANT_W'(32'(pos_r) + HDR_BYTES);
      end
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_code_r  <= res_code_r;
      out_grant_r <= res_grant_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_grant_r;
  assign out_tuser  = out_code_r;

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_idx_r == SLOT_W'(SLOTS - 1));
    sts.is_free  = is_free_r;
    sts.bad_off  = bad_r;
    sts.used     = ram_rdata.used;
    sts.at_head  = (pos_r == head_r);
    sts.cap_hit  = (steps_r == STEP_W'(WALK_CAP));
    sts.sum_eq   = sum_eq;
    sts.guard    = guard;
    sts.wrap_eq  = (hw == tail_r);
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

@@ rtl/ring_segment_buffer_allocator_top.sv @@
// Ring segment buffer allocator, top level.
// After reset the block sweeps its 8192-entry header memory clear, one slot a cycle, and
// holds in_tready low until the sweep is done. It then takes one request at a time and
// answers each with exactly one result. An allocate, and a free of a segment that is not
// at the head, each pass from transfer in to the next ready through transfer, header
// read, check and update, and result. A free whose offset names no header skips the
// update. A free at the head walks the head forward one segment per step. Each step is a
// step state and a header read state, because it reads the next header through the
// single read port of the header memory. The last step skips the header read when the
// walk stops on the tail, on the guard or on the step limit. A finished result waits in
// the output register while the next request is taken. A second result stalls in its
// last cycle until the output register is free.
// Uses rsba_pkg, rsba_ctrl and rsba_dp.
module ring_segment_buffer_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] length, [27:12] offset, [31:28] zero
  input  logic        in_tuser,   // [0] cmd: 0 allocate, 1 free
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] granted_offset
  output logic [1:0]  out_tuser   // [1:0] status
);
  import rsba_pkg::*;

  rsba_cmd_t cmd;
  rsba_sts_t sts;

  rsba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ rtl/rsba_chk.sv @@
// Port-level checker for the ring segment buffer allocator, bound to the top level.
// Uses rsba_pkg result codes.
module rsba_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import rsba_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only defined result codes appear
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == RS_OK) || (out_tuser == RS_NOSPACE) ||
                   (out_tuser == RS_GUARD))
    else $error("undefined status code");

  // A failed result grants nothing
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != RS_OK) |-> (out_tdata == 16'd0))
    else $error("offset granted on a failed result");

  // One request at a time: ready drops after each transfer in
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is at work");

endmodule

bind ring_segment_buffer_allocator_top rsba_chk u_rsba_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
